// ===== rtl/per_key_token_bucket_limiter_core_assert.svh =====
// Assertion macros for the per-key token bucket limiter.
// Clock clk and active-low reset rst_n must be in scope where they are used.
`ifndef PER_KEY_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define PER_KEY_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PKTB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pktb: property failed");
`else
`define PKTB_ASSERT(lbl, prop)
`endif

`ifndef SYNTHESIS
`define PKTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pktb: next-cycle property failed");
`else
`define PKTB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/pktb_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// per-key token bucket limiter. No dependencies.
package pktb_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int KEY_W   = 32;
    localparam int LIMIT_W = 32;
    localparam int TIME_W  = 64;

    // Elapsed time below one second fits in 30 bits.
    localparam int ELAPSED_W = 30;
    localparam int PROD_W    = ELAPSED_W + LIMIT_W;

    // product[61:30] * floor(2^61 / 1e9) >> 31 lands at most three below the quotient
    localparam int RECIP_SHIFT = 61 - ELAPSED_W;

    localparam int IN_DATA_W  = KEY_W + LIMIT_W + TIME_W;
    localparam int OUT_DATA_W = 8;

    localparam logic [TIME_W-1:0]    NS_PER_SECOND = 64'd1_000_000_000;
    localparam logic [ELAPSED_W-1:0] NS_DIVISOR    = 30'd1_000_000_000;
    localparam logic [LIMIT_W-1:0]   NS_RECIP      = 32'd2_305_843_009;
    localparam logic [LIMIT_W-1:0]   NS_X1         = 32'd1_000_000_000;
    localparam logic [LIMIT_W-1:0]   NS_X2         = 32'd2_000_000_000;
    localparam logic [LIMIT_W-1:0]   NS_X3         = 32'd3_000_000_000;

    typedef struct packed {
        logic accept;    // latch request fields
        logic lookup;    // associative match, pick slot
        logic read;      // read entry, compute elapsed
        logic mul;       // elapsed * limit
        logic est;       // reciprocal quotient estimate
        logic back;      // remainder left by the estimate
        logic fix;       // add up to three to the estimate
        logic sum;       // refill and cap tokens
        logic finish;    // write back, age update, load result
    } pktb_cmd_t;

    typedef struct packed {
        logic hit;       // lookup found the key
        logic big;       // elapsed >= one second (valid during read)
        logic out_free;  // result register can take a new result
    } pktb_stat_t;

endpackage

// ===== rtl/pktb_ctrl.sv =====
// Controller state machine for the token bucket limiter.
// Depends on pktb_pkg for command/status types.
module pktb_ctrl
    import pktb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pktb_stat_t stat,
    output pktb_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOOKUP = 4'd1;
    localparam logic [3:0] ST_READ   = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_EST    = 4'd4;
    localparam logic [3:0] ST_BACK   = 4'd5;
    localparam logic [3:0] ST_FIX    = 4'd6;
    localparam logic [3:0] ST_SUM    = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
                priority if (!stat.hit)
                    state_next = ST_FINISH;
                else if (stat.big)
                    state_next = ST_SUM;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EST;
            end
            ST_EST:
            begin
                cmd.est    = 1'b1;
                state_next = ST_BACK;
            end
            ST_BACK:
            begin
                cmd.back   = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/pktb_datapath.sv =====
// Datapath of the token bucket limiter: bucket table, LRU ages, elapsed
// multiply, reciprocal divide by 1e9, result register. Uses pktb_pkg.
module pktb_datapath
    import pktb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pktb_cmd_t          cmd,
    output pktb_stat_t         stat,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [LIMIT_W-1:0] in_limit,
    input  logic [TIME_W-1:0]  in_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_allow
);

    // bucket table
    logic                 valid_reg [TABLE_ENTRIES];
    logic [IDX_W-1:0]     age_reg   [TABLE_ENTRIES];
    logic [KEY_W-1:0]     ekey_reg  [TABLE_ENTRIES];
    logic [TIME_W-1:0]    etime_reg [TABLE_ENTRIES];
    logic [LIMIT_W-1:0]   etok_reg  [TABLE_ENTRIES];

    // request and working registers
    logic [KEY_W-1:0]     key_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 big_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [LIMIT_W-1:0]   tok_reg;
    logic [LIMIT_W-1:0]   tok_next;
    logic                 upd_reg;
    logic                 upd_next;
    logic [LIMIT_W-1:0]   rem_reg;
    logic [LIMIT_W-1:0]   rem_next;
    logic [LIMIT_W-1:0]   quo_reg;
    logic [LIMIT_W-1:0]   quo_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_allow_reg;
    logic                 out_allow_next;

    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     old_idx;
    logic [TIME_W-1:0]    elapsed_full;
    logic                 big_now;
    logic [PROD_W-1:0]    product;
    logic [2*LIMIT_W-1:0] est_full;
    logic [PROD_W-1:0]    back_full;
    logic [PROD_W-1:0]    back_diff;
    logic [1:0]           fix_add;
    logic [LIMIT_W-1:0]   refill;
    logic [LIMIT_W:0]     tok_sum;
    logic [LIMIT_W-1:0]   tok_capped;
    logic [LIMIT_W-1:0]   fill_tokens;
    logic [LIMIT_W-1:0]   wr_tokens;
    logic [IDX_W-1:0]     slot_age;

    // lowest matching valid entry; the oldest entry is the miss victim
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        old_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (ekey_reg[i] == key_reg))
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (age_reg[i] == IDX_W'(TABLE_ENTRIES - 1))
                old_idx = IDX_W'(i);
        end
    end

    assign elapsed_full = now_reg - etime_reg[slot_reg];
    assign big_now      = (elapsed_full >= NS_PER_SECOND);
    assign product      = {{LIMIT_W{1'b0}}, elapsed_reg} * {{ELAPSED_W{1'b0}}, limit_reg};

    // estimate never overshoots; the remainder left is below 4e9
    assign est_full  = {{LIMIT_W{1'b0}}, prod_reg[PROD_W-1:ELAPSED_W]}
                       * {{LIMIT_W{1'b0}}, NS_RECIP};
    assign back_full = {{ELAPSED_W{1'b0}}, quo_reg} * {{LIMIT_W{1'b0}}, NS_DIVISOR};
    assign back_diff = prod_reg - back_full;
    assign fix_add   = (rem_reg >= NS_X3) ? 2'd3 :
                       (rem_reg >= NS_X2) ? 2'd2 :
                       (rem_reg >= NS_X1) ? 2'd1 : 2'd0;

    assign refill     = big_reg ? limit_reg : quo_reg;
    assign tok_sum    = {1'b0, tok_reg} + {1'b0, refill};
    assign tok_capped = (tok_sum > {1'b0, limit_reg}) ? limit_reg : tok_sum[LIMIT_W-1:0];

    assign fill_tokens = (limit_reg == '0) ? '0 : limit_reg - 1'b1;
    assign wr_tokens   = (tok_reg == '0) ? '0 : tok_reg - 1'b1;
    assign slot_age    = age_reg[slot_reg];

    always_comb
    begin
        tok_next       = tok_reg;
        upd_next       = upd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_allow_next = out_allow_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (cmd.read)
        begin
            tok_next = etok_reg[slot_reg];
            upd_next = 1'b0;
        end
        if (cmd.est)
        begin
            quo_next = est_full[RECIP_SHIFT+LIMIT_W-1:RECIP_SHIFT];
        end
        if (cmd.back)
        begin
            rem_next = back_diff[LIMIT_W-1:0];
        end
        if (cmd.fix)
        begin
            quo_next = quo_reg + {{(LIMIT_W-2){1'b0}}, fix_add};
        end
        if (cmd.sum && (refill != '0))
        begin
            tok_next = tok_capped;
            upd_next = 1'b1;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_allow_next = hit_reg ? (tok_reg != '0) : 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= IDX_W'(i);
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                valid_reg[slot_reg] <= 1'b1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (IDX_W'(i) == slot_reg)
                        age_reg[i] <= '0;
                    else if (age_reg[i] < slot_age)
                        age_reg[i] <= age_reg[i] + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tok_reg       <= tok_next;
        upd_reg       <= upd_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_allow_reg <= out_allow_next;
        if (cmd.accept)
        begin
            key_reg   <= in_key;
            limit_reg <= in_limit;
            now_reg   <= in_time;
        end
        if (cmd.lookup)
        begin
            hit_reg  <= hit_any;
            slot_reg <= hit_any ? hit_idx : old_idx;
        end
        if (cmd.read)
        begin
            elapsed_reg <= elapsed_full[ELAPSED_W-1:0];
            big_reg     <= big_now;
        end
        if (cmd.mul)
        begin
            prod_reg <= product;
        end
        if (cmd.finish)
        begin
            if (hit_reg)
            begin
                etok_reg[slot_reg] <= wr_tokens;
                if (upd_reg)
                    etime_reg[slot_reg] <= now_reg;
            end
            else
            begin
                ekey_reg[slot_reg]  <= key_reg;
                etime_reg[slot_reg] <= now_reg;
                etok_reg[slot_reg]  <= fill_tokens;
            end
        end
    end

    assign stat.hit      = hit_reg;
    assign stat.big      = big_now;
    assign stat.out_free = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign out_allow = out_allow_reg;

endmodule

// ===== rtl/per_key_token_bucket_limiter_core.sv =====
// Per-key token bucket limiter, 16-entry fully associative LRU table.
// Path from accept to result: a miss goes lookup, read, finish; a hit with >= 1 s
// elapsed adds a refill sum; a hit with < 1 s elapsed first computes the refill
// (multiply, reciprocal estimate, back-multiply, fix-up). One request at a time; a finished
// request also waits while the previous result is still unread.
// Async active-low reset: table empty, ages 0..15, no result pending.
`include "per_key_token_bucket_limiter_core_assert.svh"

module per_key_token_bucket_limiter_core
    import pktb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // flow_key[31:0], rate_limit[63:32], time_ns[127:64]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // allow[0], zero fill [7:1]
);

    pktb_cmd_t  cmd;
    pktb_stat_t stat;
    logic       allow;

    pktb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pktb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_key    (s_tdata[KEY_W-1:0]),
        .in_limit  (s_tdata[KEY_W+LIMIT_W-1:KEY_W]),
        .in_time   (s_tdata[IN_DATA_W-1:KEY_W+LIMIT_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_allow (allow)
    );

    assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, allow};

    `PKTB_ASSERT(a_one_cmd, $onehot0(cmd))
    `PKTB_ASSERT(a_finish_needs_slot, cmd.finish |-> (!m_tvalid || m_tready))
    `PKTB_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)
    `PKTB_ASSERT_NEXT(a_finish_gives_result, cmd.finish, m_tvalid)

endmodule

// ===== verif/tb_per_key_token_bucket_limiter_core.sv =====
// Testbench for per_key_token_bucket_limiter_core: drives allow/deny requests and
// checks each answer against a token bucket table kept in step with the block.
// Depends on pktb_pkg and the core RTL only.
module tb_per_key_token_bucket_limiter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pktb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_KEYS      = 24;
    localparam int RANDOM_REQS    = 1930;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [LIMIT_W-1:0] limit;
        logic [TIME_W-1:0]  now;
    } flow_req_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // bucket table as the block should hold it
    logic               bkt_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]   bkt_key   [TABLE_ENTRIES];
    logic [TIME_W-1:0]  bkt_last  [TABLE_ENTRIES];
    logic [LIMIT_W-1:0] bkt_tokens[TABLE_ENTRIES];
    int                 bkt_age   [TABLE_ENTRIES];

    flow_req_t pending_reqs[$];
    logic      allow_expected[$];

    logic req_taken   = 1'b0;
    int   idle_cycles = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    bit   src_calm    = 1'b0;
    bit   snk_calm    = 1'b0;
    int   errors      = 0;
    int   answers     = 0;

    per_key_token_bucket_limiter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void make_youngest(input int slot);
        int old_age;
        old_age = bkt_age[slot];
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (bkt_age[i] < old_age)
                bkt_age[i]++;
        bkt_age[slot] = 0;
    endfunction

    function automatic logic bucket_decide(input logic [KEY_W-1:0] key,
                                           input logic [LIMIT_W-1:0] limit,
                                           input logic [TIME_W-1:0] now);
        int           slot;
        bit           found;
        logic [63:0]  elapsed;
        logic [127:0] prod;
        logic [63:0]  refill;
        logic [63:0]  sum;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!found && bkt_valid[i] && bkt_key[i] == key) begin
                slot  = i;
                found = 1'b1;
            end
        if (!found) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (bkt_age[i] == TABLE_ENTRIES - 1)
                    slot = i;
            bkt_valid[slot]  = 1'b1;
            bkt_key[slot]    = key;
            bkt_last[slot]   = now;
            bkt_tokens[slot] = (limit == 0) ? '0 : limit - 1;
            make_youngest(slot);
            return 1'b1;
        end
        // elapsed wraps mod 2^64, so time going backwards looks huge
        elapsed = now - bkt_last[slot];
        if (elapsed >= NS_PER_SECOND)
            refill = {32'd0, limit};
        else begin
            prod   = {64'd0, elapsed} * {96'd0, limit};
            refill = 64'(prod / {64'd0, NS_PER_SECOND});
            if (refill > {32'd0, limit})
                refill = {32'd0, limit};
        end
        // tokens above a lowered limit are only capped on a nonzero refill
        if (refill != 0) begin
            sum = {32'd0, bkt_tokens[slot]} + refill;
            if (sum > {32'd0, limit})
                sum = {32'd0, limit};
            bkt_tokens[slot] = sum[LIMIT_W-1:0];
            bkt_last[slot]   = now;
        end
        make_youngest(slot);
        if (bkt_tokens[slot] != 0) begin
            bkt_tokens[slot]--;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_req(input logic [KEY_W-1:0] key,
                                    input logic [LIMIT_W-1:0] limit,
                                    input logic [TIME_W-1:0] now);
        flow_req_t r;
        r.key   = key;
        r.limit = limit;
        r.now   = now;
        pending_reqs.push_back(r);
    endfunction

    function automatic void flag_error(input string what);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // request driver: holds a request until taken, then waits out a random gap
    always @(negedge clk) begin : source_pace
        flow_req_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                s_tdata  <= {nxt.now, nxt.limit, nxt.key};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    src_calm = !src_calm;
                gap_left <= pick_gap(src_calm);
            end else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk) begin : sink_pace
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
                snk_calm = !snk_calm;
            stall_left <= pick_gap(snk_calm);
        end
    end

    always @(posedge clk) begin : bus_monitor
        logic exp_allow;
        if (!rst_n) begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                allow_expected.push_back(bucket_decide(s_tdata[31:0], s_tdata[63:32],
                                                       s_tdata[127:64]));
            if (m_tvalid && m_tready) begin
                if (allow_expected.size() == 0)
                    flag_error($sformatf("answer %0d with no request pending, allow=%b",
                                         answers, m_tdata[0]));
                else begin
                    exp_allow = allow_expected.pop_front();
                    if (m_tdata[0] !== exp_allow)
                        flag_error($sformatf("answer %0d allow: expected %b, got %b",
                                             answers, exp_allow, m_tdata[0]));
                end
                answers <= answers + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run_ctl
        logic [KEY_W-1:0]   key_pool  [POOL_KEYS];
        logic [LIMIT_W-1:0] limit_pool[POOL_KEYS];
        logic [TIME_W-1:0]  now_t;
        logic [KEY_W-1:0]   key;
        logic [LIMIT_W-1:0] lim;
        int                 k;
        int                 r;
        bit                 timed_out;

        timed_out = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            bkt_valid[i]  = 1'b0;
            bkt_key[i]    = '0;
            bkt_last[i]   = '0;
            bkt_tokens[i] = '0;
            bkt_age[i]    = i;
        end

        // directed: first fill, empty bucket, full refill after one second
        add_req(32'd0, 32'd1, 64'd0);
        add_req(32'd0, 32'd1, 64'd1);
        add_req(32'd0, 32'd1, 64'd1_000_000_000);
        // largest limit, small refill capped at the limit, then zero limit on a hit
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd1_000_000_005);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd1_000_000_006);
        add_req(32'hFFFF_FFFF, 32'd0, 64'd1_000_000_006);
        // zero limit on a fill, then nothing to spend
        add_req(32'd5, 32'd0, 64'd2_000_000_000);
        add_req(32'd5, 32'd0, 64'd2_500_000_000);
        // tokens left above a lowered limit until a refill caps them
        add_req(32'hA5A5_A5A5, 32'd1000, 64'd3_000_000_000);
        add_req(32'hA5A5_A5A5, 32'd10, 64'd3_000_000_000);
        add_req(32'hA5A5_A5A5, 32'd10, 64'd3_200_000_000);
        // time going backwards
        add_req(32'hA5A5_A5A5, 32'd10, 64'd3_199_999_999);
        // just under one second at the widest product
        add_req(32'h1234_5678, 32'hFFFF_FFFF, 64'd4_000_000_000);
        add_req(32'h1234_5678, 32'hFFFF_FFFF, 64'd4_999_999_999);
        // top of the time range and the wrap past it
        add_req(32'd0, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(32'd0, 32'd3, 64'd0);
        add_req(32'd0, 32'd1, 64'd999_999_998);

        // random: 24 keys against 16 entries keeps eviction busy, a hot dozen gives hits
        for (int i = 0; i < POOL_KEYS; i++) begin
            key_pool[i] = $urandom;
            case ($urandom_range(0, 3))
                0:       limit_pool[i] = $urandom_range(1, 10);
                1:       limit_pool[i] = $urandom_range(100, 5000);
                2:       limit_pool[i] = $urandom_range(100_000, 2_000_000);
                default: limit_pool[i] = $urandom_range(1, 32'hFFFF_FFFF);
            endcase
        end
        now_t = {32'd0, $urandom};
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            k = (r < 80) ? $urandom_range(0, 11) : $urandom_range(12, POOL_KEYS - 1);
            key = (r >= 96) ? $urandom : key_pool[k];
            lim = limit_pool[k];
            r = $urandom_range(0, 99);
            if (r < 8)
                lim = $urandom_range(1, 100);
            else if (r < 12)
                lim = $urandom_range(1, 32'hFFFF_FFFF);
            r = $urandom_range(0, 99);
            if (r < 35)
                now_t = now_t + $urandom_range(0, 2000);
            else if (r < 70)
                now_t = now_t + $urandom_range(0, 2_000_000);
            else if (r < 90)
                now_t = now_t + $urandom_range(0, 200_000_000);
            else if (r < 97)
                now_t = now_t + $urandom_range(0, 32'd3_000_000_000);
            else
                now_t = {$urandom, $urandom};
            add_req(key, lim, now_t);
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (!timed_out && (pending_reqs.size() != 0 || s_tvalid
                              || allow_expected.size() != 0)) begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end

        if (timed_out)
            $display("tb_per_key_token_bucket_limiter_core: errors");
        else begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (allow_expected.size() != 0)
                flag_error($sformatf("%0d answers never arrived", allow_expected.size()));
            if (errors == 0)
                $display("tb_per_key_token_bucket_limiter_core: clean");
            else
                $display("tb_per_key_token_bucket_limiter_core: errors");
        end
        $finish;
    end

endmodule
